@@ design/winograd_f4x4_3x3_input_transform_unit_macros.svh @@
// assertion macros for the winograd input transform unit
`ifndef WINOGRAD_F4X4_3X3_INPUT_TRANSFORM_UNIT_MACROS_SVH
`define WINOGRAD_F4X4_3X3_INPUT_TRANSFORM_UNIT_MACROS_SVH
`ifndef SYNTH
`define WFT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wft assertion failed");
`define WFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wft assertion failed");
`else
`define WFT_ASSERT_SAME(label, clk, rst, ante, cons)
`define WFT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/wft_pkg.sv @@
// shared types, widths and transform coefficients of the winograd input transform
package wft_pkg;

  localparam int TILE     = 6;
  localparam int IDX_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int PART_W   = 20;
  localparam int OUT_W    = 24;
  localparam int KFRAC    = 14;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = PART_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;

  // b^t coefficients in q4.14
  localparam int K_ZERO = 0;
  localparam int K_ONE  = 16384;
  localparam int K_M52  = -40960;
  localparam int K_M2   = -32768;
  localparam int K_MH   = -8192;
  localparam int K_S2   = 23170;
  localparam int K_S2H  = 11585;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE - 1);

  typedef logic [0:TILE-1][COEF_W-1:0]  coef_row_t;
  typedef logic [TILE-1:0][PART_W-1:0]  part_row_t;
  typedef logic [TILE-1:0][ACC_W-1:0]   acc_row_t;
  typedef logic [TILE-1:0][OUT_W-1:0]   out_row_t;

  // one row of the table per output lane
  localparam coef_row_t BT_COEF [TILE] = '{
    '{COEF_W'(K_ONE),  COEF_W'(K_ZERO), COEF_W'(K_M52), COEF_W'(K_ZERO),
      COEF_W'(K_ONE),  COEF_W'(K_ZERO)},
    '{COEF_W'(K_ZERO), COEF_W'(-K_S2),  COEF_W'(K_M2),  COEF_W'(K_S2H),
      COEF_W'(K_ONE),  COEF_W'(K_ZERO)},
    '{COEF_W'(K_ZERO), COEF_W'(K_S2),   COEF_W'(K_M2),  COEF_W'(-K_S2H),
      COEF_W'(K_ONE),  COEF_W'(K_ZERO)},
    '{COEF_W'(K_ZERO), COEF_W'(-K_S2H), COEF_W'(K_MH),  COEF_W'(K_S2),
      COEF_W'(K_ONE),  COEF_W'(K_ZERO)},
    '{COEF_W'(K_ZERO), COEF_W'(K_S2H),  COEF_W'(K_MH),  COEF_W'(-K_S2),
      COEF_W'(K_ONE),  COEF_W'(K_ZERO)},
    '{COEF_W'(K_ZERO), COEF_W'(K_ONE),  COEF_W'(K_ZERO), COEF_W'(K_M52),
      COEF_W'(K_ZERO), COEF_W'(K_ONE)}
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] col_s0;
    logic signed [SAMPLE_W-1:0] col_s1;
    logic signed [SAMPLE_W-1:0] col_s2;
    logic signed [SAMPLE_W-1:0] col_s3;
    logic signed [SAMPLE_W-1:0] col_s4;
    logic signed [SAMPLE_W-1:0] col_s5;
  } col_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic signed [OUT_W-1:0] out_v0;
    logic signed [OUT_W-1:0] out_v1;
    logic signed [OUT_W-1:0] out_v2;
    logic signed [OUT_W-1:0] out_v3;
    logic signed [OUT_W-1:0] out_v4;
    logic signed [OUT_W-1:0] out_v5;
    logic                    tile_done;
  } row_beat_t;

endpackage

@@ design/winograd_f4x4_3x3_input_transform_unit.sv @@
// Winograd F(4x4,3x3) input transform V = B^T d B: takes one 6x6 tile as six column beats
// and returns six row beats, the last with tile_done set. Six lanes (one per output point)
// compute each six-point transform combinationally and are shared by the column pass and the
// row pass, followed by a round-and-clip merge stage. Columns are taken one per cycle while
// col_stall is low; after the sixth column the unit waits in ST_WAIT while it lands in the
// store, then the six rows issue one per cycle while row_stall allows, with columns stalled.
// An issued row passes through the s1 register and the merge into the output register, which
// holds a row until it is taken, and a new tile's columns may enter while the last row waits there.
`include "winograd_f4x4_3x3_input_transform_unit_macros.svh"
module winograd_f4x4_3x3_input_transform_unit import wft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      col_valid,
  output logic      col_stall,
  input  col_beat_t col_beat,
  output logic      row_valid,
  input  logic      row_stall,
  output row_beat_t row_beat
);

  typedef enum logic [1:0] {ST_COLLECT, ST_WAIT, ST_ROWS} state_t;

  typedef struct packed {
    logic             valid;
    logic             is_col;
    logic [IDX_W-1:0] idx;
  } s1_ctl_t;

  state_t           state;
  logic [IDX_W-1:0] col_cnt;
  logic [IDX_W-1:0] row_cnt;
  s1_ctl_t          s1_ctl;
  acc_row_t         s1_sum;
  part_row_t        partial_tile [TILE];

  part_row_t col_x;
  part_row_t lane_x;
  acc_row_t  lane_sum;
  part_row_t mrg_part;
  out_row_t  mrg_out;

  logic out_load;
  logic s1_go;
  logic s1_free;
  logic col_acc;
  logic row_issue;

  assign col_x[0] = {{(PART_W-SAMPLE_W){col_beat.col_s0[SAMPLE_W-1]}}, col_beat.col_s0};
  assign col_x[1] = {{(PART_W-SAMPLE_W){col_beat.col_s1[SAMPLE_W-1]}}, col_beat.col_s1};
  assign col_x[2] = {{(PART_W-SAMPLE_W){col_beat.col_s2[SAMPLE_W-1]}}, col_beat.col_s2};
  assign col_x[3] = {{(PART_W-SAMPLE_W){col_beat.col_s3[SAMPLE_W-1]}}, col_beat.col_s3};
  assign col_x[4] = {{(PART_W-SAMPLE_W){col_beat.col_s4[SAMPLE_W-1]}}, col_beat.col_s4};
  assign col_x[5] = {{(PART_W-SAMPLE_W){col_beat.col_s5[SAMPLE_W-1]}}, col_beat.col_s5};

  // lanes see the incoming column while collecting, else one stored row
  assign lane_x = (state == ST_COLLECT) ? col_x : partial_tile[row_cnt];

  for (genvar g = 0; g < TILE; g++) begin : g_lane
    wft_lane u_lane (
      .coef (BT_COEF[g]),
      .x    (lane_x),
      .sum  (lane_sum[g])
    );
  end

  wft_merge u_merge (
    .sums (s1_sum),
    .part (mrg_part),
    .vout (mrg_out)
  );

  assign out_load  = !row_valid || !row_stall;
  // a column result always drains into the store, a row needs the output register
  assign s1_go     = s1_ctl.is_col || out_load;
  assign s1_free   = !s1_ctl.valid || s1_go;
  assign col_stall = !((state == ST_COLLECT) && s1_free);
  assign col_acc   = col_valid && !col_stall;
  assign row_issue = (state == ST_ROWS) && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      col_cnt   <= '0;
      row_cnt   <= '0;
      s1_ctl    <= '0;
      row_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (col_acc) begin
            if (col_cnt == LAST_IDX) begin
              col_cnt <= '0;
              state   <= ST_WAIT;
            end else begin
              col_cnt <= col_cnt + IDX_W'(1);
            end
          end
        end
        ST_WAIT: begin
          row_cnt <= '0;
          state   <= ST_ROWS;
        end
        ST_ROWS: begin
          if (row_issue) begin
            if (row_cnt == LAST_IDX) begin
              row_cnt <= '0;
              state   <= ST_COLLECT;
            end else begin
              row_cnt <= row_cnt + IDX_W'(1);
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase

      if (col_acc) begin
        s1_ctl <= '{valid: 1'b1, is_col: 1'b1, idx: col_cnt};
      end else if (row_issue) begin
        s1_ctl <= '{valid: 1'b1, is_col: 1'b0, idx: row_cnt};
      end else if (s1_go) begin
        s1_ctl.valid <= 1'b0;
      end

      if (out_load) begin
        row_valid <= s1_ctl.valid && !s1_ctl.is_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_acc || row_issue) begin
      s1_sum <= lane_sum;
    end
    if (out_load && s1_ctl.valid && !s1_ctl.is_col) begin
      row_beat.row_index <= s1_ctl.idx;
      row_beat.out_v0    <= mrg_out[0];
      row_beat.out_v1    <= mrg_out[1];
      row_beat.out_v2    <= mrg_out[2];
      row_beat.out_v3    <= mrg_out[3];
      row_beat.out_v4    <= mrg_out[4];
      row_beat.out_v5    <= mrg_out[5];
      row_beat.tile_done <= (s1_ctl.idx == LAST_IDX);
    end
  end

  // column pass results land in the store, one column a beat
  always_ff @(posedge clk) begin
    if (s1_ctl.valid && s1_ctl.is_col) begin
      for (int k = 0; k < TILE; k++) begin
        partial_tile[k][s1_ctl.idx] <= mrg_part[k];
      end
    end
  end

  `WFT_ASSERT_NEXT(a_no_col_after_last, clk, rst, col_acc && (col_cnt == LAST_IDX), col_stall)
  `WFT_ASSERT_SAME(a_no_store_write_in_rows, clk, rst, s1_ctl.valid && s1_ctl.is_col, state != ST_ROWS)
  `WFT_ASSERT_NEXT(a_wait_one_cycle, clk, rst, state == ST_WAIT, (state == ST_ROWS) && !s1_ctl.valid)

endmodule

@@ design/wft_lane.sv @@
// one transform lane: exact q14 dot product of a six-point vector with one coefficient row
module wft_lane import wft_pkg::*; (
  input  coef_row_t               coef,
  input  part_row_t               x,
  output logic signed [ACC_W-1:0] sum
);

  logic signed [COEF_W-1:0] cf;
  logic signed [PART_W-1:0] xk;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    sum  = '0;
    cf   = '0;
    xk   = '0;
    prod = '0;
    for (int k = 0; k < TILE; k++) begin
      cf   = $signed(coef[k]);
      xk   = $signed(x[k]);
      prod = cf * xk;
      sum  = sum + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

@@ design/wft_merge.sv @@
// merge stage: rounds the six lane sums half up and clips them to store and output widths
module wft_merge import wft_pkg::*; (
  input  acc_row_t  sums,
  output part_row_t part,
  output out_row_t  vout
);

  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) <<< (KFRAC - 1);
  localparam logic signed [ACC_W-1:0] PART_HI =
    {{(ACC_W-PART_W+1){1'b0}}, {(PART_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] PART_LO =
    {{(ACC_W-PART_W+1){1'b1}}, {(PART_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] OUT_HI =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_LO =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [ACC_W-1:0] rnd [TILE];

  always_comb begin
    for (int k = 0; k < TILE; k++) begin
      // arithmetic shift gives floor, matching round half up
      rnd[k] = ($signed(sums[k]) + RND) >>> KFRAC;
      if (rnd[k] > PART_HI) begin
        part[k] = PART_HI[PART_W-1:0];
      end else if (rnd[k] < PART_LO) begin
        part[k] = PART_LO[PART_W-1:0];
      end else begin
        part[k] = rnd[k][PART_W-1:0];
      end
      if (rnd[k] > OUT_HI) begin
        vout[k] = OUT_HI[OUT_W-1:0];
      end else if (rnd[k] < OUT_LO) begin
        vout[k] = OUT_LO[OUT_W-1:0];
      end else begin
        vout[k] = rnd[k][OUT_W-1:0];
      end
    end
  end

endmodule
